[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of aclk, quiet while reset is applied.
`define TCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same check, also evaluated during reset.
`define TCL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[rtl/tclux_pkg.sv]
package tclux_pkg;

    localparam int COUNT_BITS        = 16;
    localparam int POWER_TABLE_STEPS = 32;
    localparam int TWO_STEPS         = 2 * POWER_TABLE_STEPS;

    // Ratio quotient: 16 fraction bits plus one integer bit.
    localparam int QW      = 17;
    localparam int DIV_SP  = 4;
    localparam int DIV_STG = (QW + DIV_SP - 1) / DIV_SP;

    localparam int SH_W      = 3;
    localparam int SCALE_MAX = 4;
    localparam int S_W       = COUNT_BITS + SCALE_MAX;
    localparam int LUX_W     = 19;
    localparam int TAB_W     = 17;
    localparam int IDX_W     = $clog2(POWER_TABLE_STEPS + 1);
    localparam int P_W       = QW + $clog2(TWO_STEPS + 1);
    localparam int COEF_W    = 12;
    localparam int K_W       = 36;
    localparam int V_W       = 64;

    localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

    localparam logic [QW-1:0] R_050 = QW'(32768);
    localparam logic [QW-1:0] R_061 = QW'(39977);
    localparam logic [QW-1:0] R_080 = QW'(52429);
    localparam logic [QW-1:0] R_130 = QW'(85197);

    localparam logic [COEF_W-1:0] C_B1_A = COEF_W'(1992);
    localparam logic [COEF_W-1:0] C_B1_B = COEF_W'(4063);
    localparam logic [COEF_W-1:0] C_B2_A = COEF_W'(1468);
    localparam logic [COEF_W-1:0] C_B2_B = COEF_W'(2032);
    localparam logic [COEF_W-1:0] C_B3_A = COEF_W'(839);
    localparam logic [COEF_W-1:0] C_B3_B = COEF_W'(1003);
    localparam logic [COEF_W-1:0] C_B4_A = COEF_W'(96);
    localparam logic [COEF_W-1:0] C_B4_B = COEF_W'(73);

    localparam logic [SH_W-1:0] SCALE_RESET = SH_W'(4);

    typedef enum logic [2:0] {
        BAND_NONE = 3'd0,
        BAND_1    = 3'd1,
        BAND_2    = 3'd2,
        BAND_3    = 3'd3,
        BAND_4    = 3'd4,
        BAND_HIGH = 3'd5
    } band_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] c0;
        logic [COUNT_BITS-1:0] c1;
        logic [COUNT_BITS-1:0] rem;
        logic [QW-1:0]         q;
        logic                  zero;
        logic                  ovf;
        logic [SH_W-1:0]       sh;
    } div_t;

    typedef logic [TAB_W-1:0] pow_tab_t [POWER_TABLE_STEPS + 1];

    // Entry k is the largest Y with Y^5 * D^7 <= k^7 * 2^80, D = 2 * steps.
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t     t;
        logic [191:0] rhs;
        logic [191:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        for (int k = 0; k <= POWER_TABLE_STEPS; k++) begin
            rhs = 192'd1;
            for (int e = 0; e < 7; e++) rhs = rhs * 192'(k);
            rhs = rhs << 80;
            lo = 0;
            hi = 65536;
            for (int it = 0; it < 20; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 1) / 2;
                    lhs = 192'd1;
                    for (int e = 0; e < 5; e++) lhs = lhs * 192'(mid);
                    for (int e = 0; e < 7; e++) lhs = lhs * 192'(TWO_STEPS);
                    if (lhs <= rhs) lo = mid;
                    else hi = mid - 1;
                end
            end
            t[k] = TAB_W'(lo);
        end
        return t;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

[rtl/two_channel_lux_calculator.sv]
// Channel | Direction | Contents
// s_      | in        | tdata: broadband_count[15:0], infrared_count[31:16]
// m_      | out       | tdata: lux_sixteenths[18:0]; tuser: ratio_band[2:0]
// apb     | in/out    | scale_shift at byte address 0
//
// One beat can enter every cycle unless a stall at the output has filled the pipeline.
// The ratio divider forms up to four quotient bits per stage.
// Reset clears all valid bits and loads scale_shift with 4.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and nothing is lost or repeated.
`include "assert_macros.svh"

module two_channel_lux_calculator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // broadband_count [15:0], infrared_count [31:16]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // lux_sixteenths [18:0], zero padding [23:19]
    output logic [23:0] m_tdata,
    // ratio_band [2:0]
    output logic [2:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CB = tclux_pkg::COUNT_BITS;
    localparam int NS = tclux_pkg::DIV_STG;

    // Configuration register.
    logic [tclux_pkg::SH_W-1:0] scale_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= tclux_pkg::SCALE_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            scale_reg <= pwdata[tclux_pkg::SH_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (!paddr[2]) prdata = {{(32 - tclux_pkg::SH_W){1'b0}}, scale_reg};
    end

    // Stage enables, from the output back to the input.
    logic          en_out;
    logic          en_p3;
    logic          en_p2;
    logic          en_p1;
    logic [NS-1:0] div_en;

    logic          out_v_reg;
    logic          p3_v_reg;
    logic          p2_v_reg;
    logic          p1_v_reg;
    logic [NS-1:0] dv_reg;

    always_comb begin
        en_out = !out_v_reg || m_tready;
        en_p3  = !p3_v_reg || en_out;
        en_p2  = !p2_v_reg || en_p3;
        en_p1  = !p1_v_reg || en_p2;
        for (int s = NS - 1; s >= 0; s--) begin
            if (s == NS - 1) div_en[s] = !dv_reg[s] || en_p1;
            else div_en[s] = !dv_reg[s] || div_en[s + 1];
        end
    end

    assign s_tready = div_en[0];

    // Restoring divider: the remainder stays below the divisor except when ovf is set.
    function automatic tclux_pkg::div_t div_steps(input int stg, input tclux_pkg::div_t d);
        tclux_pkg::div_t r;
        logic [CB:0]     t;
        int              g;
        r = d;
        for (int j = 0; j < tclux_pkg::DIV_SP; j++) begin
            g = stg * tclux_pkg::DIV_SP + j;
            if (g < tclux_pkg::QW) begin
                t = {r.rem, (g == 0) ? r.c1[0] : 1'b0};
                if (t >= {1'b0, r.c0}) begin
                    t     = t - {1'b0, r.c0};
                    r.rem = t[CB-1:0];
                    r.q   = {r.q[tclux_pkg::QW-2:0], 1'b1};
                end else begin
                    r.rem = t[CB-1:0];
                    r.q   = {r.q[tclux_pkg::QW-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

    tclux_pkg::div_t dd_reg [NS];
    tclux_pkg::div_t div_in [NS];

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                div_in[s].c0   = s_tdata[CB-1:0];
                div_in[s].c1   = s_tdata[16 +: CB];
                div_in[s].rem  = {1'b0, s_tdata[16 + 1 +: CB - 1]};
                div_in[s].q    = '0;
                div_in[s].zero = (s_tdata[CB-1:0] == '0) || (s_tdata[16 +: CB] == '0);
                div_in[s].ovf  = {1'b0, s_tdata[16 +: CB]} >= {s_tdata[CB-1:0], 1'b0};
                div_in[s].sh   = (scale_reg > tclux_pkg::SH_W'(tclux_pkg::SCALE_MAX))
                               ? tclux_pkg::SH_W'(tclux_pkg::SCALE_MAX) : scale_reg;
            end else begin
                div_in[s] = dd_reg[s - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (div_en[s]) dd_reg[s] <= div_steps(s, div_in[s]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (div_en[s]) dv_reg[s] <= (s == 0) ? s_tvalid : dv_reg[s - 1];
            end
        end
    end

    // Stage 1: band choice and table lookup.
    tclux_pkg::div_t             dlast;
    logic [tclux_pkg::P_W-1:0]   pos;
    logic [tclux_pkg::P_W-17:0]  seg;
    logic                        seg_last;
    logic [tclux_pkg::IDX_W-1:0] seg_idx;
    logic [tclux_pkg::TAB_W-1:0] tab_lo;
    logic [tclux_pkg::TAB_W-1:0] tab_hi;
    tclux_pkg::band_t            band_c;

    assign dlast    = dd_reg[NS - 1];
    assign pos      = tclux_pkg::P_W'(dlast.q) * tclux_pkg::P_W'(tclux_pkg::TWO_STEPS);
    assign seg      = pos[tclux_pkg::P_W-1:16];
    assign seg_last = seg >= (tclux_pkg::P_W - 16)'(tclux_pkg::POWER_TABLE_STEPS);
    assign seg_idx  = seg_last ? '0 : seg[tclux_pkg::IDX_W-1:0];
    assign tab_lo   = tclux_pkg::POW_TAB[seg_idx];
    assign tab_hi   = tclux_pkg::POW_TAB[seg_idx + 1'b1];

    always_comb begin
        if (dlast.zero) band_c = tclux_pkg::BAND_NONE;
        else if (dlast.ovf || dlast.q > tclux_pkg::R_130) band_c = tclux_pkg::BAND_HIGH;
        else if (dlast.q <= tclux_pkg::R_050) band_c = tclux_pkg::BAND_1;
        else if (dlast.q <= tclux_pkg::R_061) band_c = tclux_pkg::BAND_2;
        else if (dlast.q <= tclux_pkg::R_080) band_c = tclux_pkg::BAND_3;
        else band_c = tclux_pkg::BAND_4;
    end

    tclux_pkg::band_t            p1_band_reg;
    logic [tclux_pkg::TAB_W-1:0] p1_lo_reg;
    logic [tclux_pkg::TAB_W+15:0] p1_prod_reg;
    logic                        p1_last_reg;
    logic [tclux_pkg::S_W-1:0]   p1_s0_reg;
    logic [tclux_pkg::S_W-1:0]   p1_s1_reg;

    always_ff @(posedge aclk) begin
        if (en_p1) begin
            p1_band_reg <= band_c;
            p1_lo_reg   <= tab_lo;
            p1_prod_reg <= (tclux_pkg::TAB_W + 16)'(tab_hi - tab_lo)
                         * (tclux_pkg::TAB_W + 16)'(pos[15:0]);
            p1_last_reg <= seg_last;
            p1_s0_reg   <= tclux_pkg::S_W'(dlast.c0) << dlast.sh;
            p1_s1_reg   <= tclux_pkg::S_W'(dlast.c1) << dlast.sh;
        end
    end

    // Stage 2: power term and coefficient products.
    logic [tclux_pkg::TAB_W-1:0]  pw;
    logic [tclux_pkg::COEF_W-1:0] coef_a;
    logic [tclux_pkg::COEF_W-1:0] coef_b;

    assign pw = p1_last_reg ? tclux_pkg::POW_TAB[tclux_pkg::POWER_TABLE_STEPS]
                            : p1_lo_reg + p1_prod_reg[tclux_pkg::TAB_W+15:16];

    always_comb begin
        case (p1_band_reg)
            tclux_pkg::BAND_2: begin
                coef_a = tclux_pkg::C_B2_A;
                coef_b = tclux_pkg::C_B2_B;
            end
            tclux_pkg::BAND_3: begin
                coef_a = tclux_pkg::C_B3_A;
                coef_b = tclux_pkg::C_B3_B;
            end
            tclux_pkg::BAND_4: begin
                coef_a = tclux_pkg::C_B4_A;
                coef_b = tclux_pkg::C_B4_B;
            end
            default: begin
                coef_a = tclux_pkg::C_B1_A;
                coef_b = tclux_pkg::C_B1_B;
            end
        endcase
    end

    tclux_pkg::band_t               p2_band_reg;
    logic signed [tclux_pkg::K_W-1:0] p2_k_reg;
    logic [31:0]                    p2_m0_reg;
    logic [31:0]                    p2_m1_reg;
    logic [tclux_pkg::S_W-1:0]      p2_s0_reg;

    always_ff @(posedge aclk) begin
        if (en_p2) begin
            p2_band_reg <= p1_band_reg;
            p2_k_reg    <= $signed(tclux_pkg::K_W'(tclux_pkg::C_B1_A) << 16)
                         - $signed(tclux_pkg::K_W'(tclux_pkg::C_B1_B) * tclux_pkg::K_W'(pw));
            p2_m0_reg   <= 32'(coef_a) * 32'(p1_s0_reg);
            p2_m1_reg   <= 32'(coef_b) * 32'(p1_s1_reg);
            p2_s0_reg   <= p1_s0_reg;
        end
    end

    // Stage 3: accumulator in Q32 lux.
    logic signed [32:0] diff_c;

    assign diff_c = $signed({1'b0, p2_m0_reg}) - $signed({1'b0, p2_m1_reg});

    tclux_pkg::band_t                 p3_band_reg;
    logic signed [tclux_pkg::V_W-1:0] p3_acc_reg;

    always_ff @(posedge aclk) begin
        if (en_p3) begin
            p3_band_reg <= p2_band_reg;
            if (p2_band_reg == tclux_pkg::BAND_1) begin
                p3_acc_reg <= tclux_pkg::V_W'(p2_k_reg)
                            * $signed({{(tclux_pkg::V_W - tclux_pkg::S_W){1'b0}}, p2_s0_reg});
            end else begin
                p3_acc_reg <= tclux_pkg::V_W'(diff_c) <<< 16;
            end
        end
    end

    // Output stage: clamp, saturate.
    logic [tclux_pkg::V_W-29:0] acc_q;
    logic [tclux_pkg::LUX_W-1:0] lux_c;

    assign acc_q = p3_acc_reg[tclux_pkg::V_W-1:28];

    always_comb begin
        if (p3_band_reg == tclux_pkg::BAND_NONE || p3_band_reg == tclux_pkg::BAND_HIGH
            || p3_acc_reg <= 0) begin
            lux_c = '0;
        end else if (acc_q > (tclux_pkg::V_W - 28)'(tclux_pkg::LUX_MAX)) begin
            lux_c = tclux_pkg::LUX_MAX;
        end else begin
            lux_c = acc_q[tclux_pkg::LUX_W-1:0];
        end
    end

    logic [tclux_pkg::LUX_W-1:0] out_lux_reg;
    tclux_pkg::band_t            out_band_reg;

    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_lux_reg  <= lux_c;
            out_band_reg <= p3_band_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (en_p1) p1_v_reg <= dv_reg[NS - 1];
            if (en_p2) p2_v_reg <= p1_v_reg;
            if (en_p3) p3_v_reg <= p2_v_reg;
            if (en_out) out_v_reg <= p3_v_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(24 - tclux_pkg::LUX_W){1'b0}}, out_lux_reg};
    assign m_tuser  = out_band_reg;

    `TCL_ASSERT(a_band_range, m_tvalid |-> m_tuser <= 3'd5, "ratio band out of range")
    `TCL_ASSERT(a_no_lux_out_of_band,
        m_tvalid && (m_tuser == 3'd0 || m_tuser == 3'd5) |-> m_tdata == 24'd0,
        "lux given for a zero or high ratio band")
    `TCL_ASSERT_ALWAYS(a_stall_only_when_full,
        !s_tready |-> m_tvalid && !m_tready,
        "input stalled while the output is free")

endmodule
